### design/spma_pkg.sv
// Shared types, codes and sizing constants for the segmented protected memory port.
package spma_pkg;

    localparam int SEGMENTS_DEF     = 4;
    localparam int MEMORY_WORDS_DEF = 4096;
    localparam int MAX_SEGMENTS     = 4;

    localparam int ADDR_W      = 32;
    localparam int DATA_W      = 32;
    localparam int RANGE_W     = 64;
    localparam int MAP_BITS    = 15;
    localparam int OFFSET_BITS = 12;
    localparam int WORD_BITS   = ADDR_W - 2;
    localparam int CFG_IDX_W   = 3;

    // Attribute bit positions inside one segment's map field.
    localparam int ATTR_R_BIT = 12;
    localparam int ATTR_W_BIT = 13;
    localparam int ATTR_X_BIT = 14;

    // Configuration register indexes beyond the segment ranges.
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_MAP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PROT    = 3'd5;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_FETCH = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [1:0]        access_size;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              fault;
    } t_rsp;

    // Outcome of segment lookup and protection check for one transaction.
    typedef struct packed {
        logic                 fault;
        logic                 is_write;
        logic [1:0]           size;
        logic [1:0]           lane;
        logic [WORD_BITS-1:0] word;
    } t_dec;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_MOD,
        ST_READ,
        ST_ACCESS
    } t_state;

endpackage

### design/segmented_protected_memory_access.sv
// Top level: segmented, protected memory port with a cleared word memory behind it.
// Sequence: an accepted transaction is decoded, its word index is reduced (the low bits when
// MEMORY_WORDS is a power of two, a reciprocal word index reduction otherwise), the word is
// read and the result is loaded; a faulting transaction skips the reduction and the read.
// Only one transaction is in flight: the next is accepted once the result is loaded.
// Reset: configuration clears to zero, then a clearing pass zeroes every memory word in
// turn, during which no transaction is accepted; configuration writes are taken.
module segmented_protected_memory_access #(
    parameter int SEGMENTS     = spma_pkg::SEGMENTS_DEF,
    parameter int MEMORY_WORDS = spma_pkg::MEMORY_WORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [spma_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [spma_pkg::RANGE_W-1:0]   i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  spma_pkg::t_req                 i_in_req,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output spma_pkg::t_rsp                 o_out_rsp
);
    import spma_pkg::*;

    localparam int AW = $clog2(MEMORY_WORDS);
    localparam logic [AW-1:0] LAST_WORD = AW'(MEMORY_WORDS - 1);

    // Configuration registers. Each segment range is written by its own index.
    logic [SEGMENTS-1:0][RANGE_W-1:0]  r_seg_range;
    logic [SEGMENTS*MAP_BITS-1:0]      r_seg_map;
    logic                              r_prot;

    for (genvar g = 0; g < SEGMENTS; g++) begin : g_cfg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_seg_range[g] <= '0;
            end else if (i_cfg_we && i_cfg_index == CFG_IDX_W'(g)) begin
                r_seg_range[g] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_map <= '0;
            r_prot    <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_SEG_MAP) begin
                r_seg_map <= i_cfg_data[SEGMENTS*MAP_BITS-1:0];
            end
            if (i_cfg_index == CFG_PROT) begin
                r_prot <= i_cfg_data[0];
            end
        end
    end

    // Sequencer state and the transaction being worked on.
    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_clr;
    t_req          r_req;
    t_dec          r_dec;
    t_dec          dec;
    logic          r_out_valid;
    t_rsp          r_rsp;

    logic              out_free;
    logic              in_fire;
    logic              mod_start;
    logic              mod_done;
    logic [AW-1:0]     widx;
    logic              ram_re;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;
    logic              clearing;
    logic              out_load;
    logic              mem_write;

    assign out_free = !r_out_valid || i_out_ready;
    assign in_fire  = i_in_valid && o_in_ready;

    spma_decode #(
        .SEGMENTS(SEGMENTS)
    ) u_decode (
        .i_req      (r_req),
        .i_seg_range(r_seg_range),
        .i_seg_map  (r_seg_map),
        .i_prot     (r_prot),
        .o_dec      (dec)
    );

    spma_word_mod #(
        .MEMORY_WORDS(MEMORY_WORDS),
        .AW          (AW)
    ) u_word_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mod_start),
        .i_value(dec.word),
        .o_done (mod_done),
        .o_index(widx)
    );

    spma_ram #(
        .DEPTH(MEMORY_WORDS),
        .AW   (AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(widx),
        .o_rdata(ram_rdata)
    );

    // Next-state logic. A fault skips the index reduction and the memory read.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == LAST_WORD) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                n_state = dec.fault ? ST_ACCESS : ST_MOD;
            end
            ST_MOD: begin
                if (mod_done) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_ACCESS;
            end
            ST_ACCESS: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        o_in_ready = 1'b0;
        clearing   = 1'b0;
        mod_start  = 1'b0;
        ram_re     = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_CLEAR:  clearing   = 1'b1;
            ST_IDLE:   o_in_ready = 1'b1;
            ST_DECODE: mod_start  = !dec.fault;
            ST_READ:   ram_re     = 1'b1;
            ST_ACCESS: out_load   = out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr <= r_clr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req <= i_in_req;
        end
        if (r_state == ST_DECODE) begin
            r_dec <= dec;
        end
    end

    // Lane handling. Lane 0 is the most significant byte, so a byte sits
    // (3 - lane) bytes up and a halfword at lane 0 or 1 is the upper half.
    logic [4:0]        lane_shift;
    logic [DATA_W-1:0] size_mask;
    logic [DATA_W-1:0] rd_value;
    logic [DATA_W-1:0] merged;

    always_comb begin
        case (r_dec.size)
            SIZE_BYTE: begin
                lane_shift = {~r_dec.lane, 3'b000};
                size_mask  = DATA_W'(8'hFF);
            end
            SIZE_HALF: begin
                lane_shift = {~r_dec.lane[1], 4'b0000};
                size_mask  = DATA_W'(16'hFFFF);
            end
            default: begin
                lane_shift = '0;
                size_mask  = '1;
            end
        endcase
    end

    assign rd_value = (ram_rdata >> lane_shift) & size_mask;
    assign merged   = (ram_rdata & ~(size_mask << lane_shift))
                    | ((r_req.write_data & size_mask) << lane_shift);

    // The read-modify-write completes in the cycle the result is loaded, and
    // only one transaction is in flight, so no two accesses to a word overlap.
    assign mem_write = out_load && r_dec.is_write && !r_dec.fault;
    assign ram_we    = clearing || mem_write;
    assign ram_waddr = clearing ? r_clr : widx;
    assign ram_wdata = clearing ? '0 : merged;

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_rsp.fault <= r_dec.fault;
            if (r_dec.fault) begin
                r_rsp.read_data <= size_mask;
            end else if (r_dec.is_write) begin
                r_rsp.read_data <= '0;
            end else begin
                r_rsp.read_data <= rd_value;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

    // A faulting transaction must never reach the memory write port.
    a_no_fault_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACCESS && ram_we) |-> !r_dec.fault)
        else $error("memory written by a faulting transaction");

    // A pending result that is not taken holds the sequencer in the access step.
    a_hold_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACCESS && r_out_valid && !i_out_ready) |=> r_state == ST_ACCESS)
        else $error("result overwritten before it was taken");

    // An accepted transaction always goes to the decode step next.
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == ST_DECODE)
        else $error("accepted transaction not decoded");

    // The index reduction only finishes while the sequencer waits for it.
    a_mod_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> r_state == ST_MOD)
        else $error("word index ready outside the wait step");

endmodule

### design/spma_decode.sv
// Segment lookup, permission check and physical byte address formation.
module spma_decode #(
    parameter int SEGMENTS = spma_pkg::SEGMENTS_DEF
) (
    input  spma_pkg::t_req                                      i_req,
    input  logic [SEGMENTS-1:0][spma_pkg::RANGE_W-1:0]          i_seg_range,
    input  logic [SEGMENTS*spma_pkg::MAP_BITS-1:0]              i_seg_map,
    input  logic                                                i_prot,
    output spma_pkg::t_dec                                      o_dec
);
    import spma_pkg::*;

    logic [SEGMENTS-1:0]             seg_hit;
    logic [SEGMENTS-1:0][ADDR_W-1:0] seg_off;
    logic                            hit;
    logic [ADDR_W-1:0]               sel_off;
    logic [MAP_BITS-1:0]             sel_map;
    logic                            perm;
    logic [ADDR_W-1:0]               phys;
    logic [1:0]                      size_n;

    // Every segment is compared in parallel; the lowest hit wins below.
    for (genvar g = 0; g < SEGMENTS; g++) begin : g_seg
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] span;
        assign base       = i_seg_range[g][ADDR_W-1:0];
        assign span       = i_seg_range[g][RANGE_W-1:ADDR_W];
        assign seg_off[g] = i_req.address - base;
        assign seg_hit[g] = (i_req.address >= base) && (seg_off[g] < span);
    end

    always_comb begin
        hit     = 1'b0;
        sel_off = '0;
        sel_map = '0;
        for (int i = SEGMENTS - 1; i >= 0; i--) begin
            if (seg_hit[i]) begin
                hit     = 1'b1;
                sel_off = seg_off[i];
                sel_map = i_seg_map[i*MAP_BITS +: MAP_BITS];
            end
        end
    end

    always_comb begin
        unique case (i_req.func)
            FUNC_READ:  perm = sel_map[ATTR_R_BIT];
            FUNC_WRITE: perm = sel_map[ATTR_W_BIT];
            FUNC_FETCH: perm = sel_map[ATTR_R_BIT] & sel_map[ATTR_X_BIT];
            default:    perm = 1'b0;
        endcase
    end

    // A fetch is always a byte; the unused size code behaves as a word.
    always_comb begin
        if (i_req.func == FUNC_FETCH) begin
            size_n = SIZE_BYTE;
        end else if (i_req.access_size == SIZE_BYTE || i_req.access_size == SIZE_HALF) begin
            size_n = i_req.access_size;
        end else begin
            size_n = SIZE_WORD;
        end
    end

    assign phys = ADDR_W'({sel_map[OFFSET_BITS-1:0], 2'b00}) + sel_off;

    always_comb begin
        o_dec.fault    = (i_req.func != FUNC_READ && i_req.func != FUNC_WRITE
                          && i_req.func != FUNC_FETCH) || !hit || (i_prot && !perm);
        o_dec.is_write = (i_req.func == FUNC_WRITE);
        o_dec.size     = size_n;
        o_dec.lane     = phys[1:0];
        o_dec.word     = phys[ADDR_W-1:2];
    end

endmodule

### design/spma_word_mod.sv
// Reduces a physical word number modulo the memory depth.
module spma_word_mod #(
    parameter int MEMORY_WORDS = spma_pkg::MEMORY_WORDS_DEF,
    parameter int AW           = $clog2(MEMORY_WORDS)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [spma_pkg::WORD_BITS-1:0] i_value,
    output logic                           o_done,
    output logic [AW-1:0]                  o_index
);
    import spma_pkg::*;

    logic [AW-1:0] r_rem;
    logic          r_done;

    if ((MEMORY_WORDS & (MEMORY_WORDS - 1)) == 0) begin : g_pow2
        // Depth is a power of two: the remainder is the low bits.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_start;
            end
            if (i_start) begin
                r_rem <= i_value[AW-1:0];
            end
        end
    end else begin : g_recip
        // The quotient estimate, the value times floor(2^32 / depth) shifted down by 32,
        // is at most one below the true quotient because the value is below 2^30, so a
        // single compare and subtract finishes the remainder. Only the low bits of the
        // partial remainder are kept, since it is always below twice the depth.
        localparam logic [AW:0] DEPTH  = (AW+1)'(MEMORY_WORDS);
        localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / MEMORY_WORDS);
        localparam int          PROD_W = WORD_BITS + 32;

        logic [WORD_BITS-1:0] r_val;
        logic [WORD_BITS-1:0] r_quot;
        logic [AW:0]          r_raw;
        logic                 r_s1;
        logic                 r_s2;
        logic                 r_s3;
        logic [PROD_W-1:0]    prod;

        assign prod = PROD_W'(r_val) * PROD_W'(RECIP);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s1   <= 1'b0;
                r_s2   <= 1'b0;
                r_s3   <= 1'b0;
                r_done <= 1'b0;
            end else begin
                r_s1   <= i_start;
                r_s2   <= r_s1;
                r_s3   <= r_s2;
                r_done <= r_s3;
            end
            if (i_start) begin
                r_val <= i_value;
            end
            if (r_s1) begin
                r_quot <= prod[PROD_W-1:32];
            end
            if (r_s2) begin
                r_raw <= (AW+1)'(r_val) - (AW+1)'(r_quot) * DEPTH;
            end
            if (r_s3) begin
                r_rem <= (r_raw >= DEPTH) ? AW'(r_raw - DEPTH) : AW'(r_raw);
            end
        end
    end

    assign o_done  = r_done;
    assign o_index = r_rem;

endmodule

### design/spma_ram.sv
// Single-port-write, single-port-read word memory with a registered read.
module spma_ram #(
    parameter int DEPTH = spma_pkg::MEMORY_WORDS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [spma_pkg::DATA_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [spma_pkg::DATA_W-1:0] o_rdata
);
    import spma_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### tb/sv/segmented_protected_memory_access_tb.sv
// Self-checking testbench for the segmented protected memory port, with its own access predictor.
module segmented_protected_memory_access_tb;
    import spma_pkg::*;

    // Codes that the package does not name: the unused function and size codes and the
    // register indexes around the named ones.
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam logic [1:0] SIZE_WIDE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_RANGE0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B    = 3'd7;

    // Permission sets as they sit above the offset in one segment field: {X, W, R}.
    localparam logic [2:0] PERM_NONE = 3'b000;
    localparam logic [2:0] PERM_R    = 3'b001;
    localparam logic [2:0] PERM_W    = 3'b010;
    localparam logic [2:0] PERM_X    = 3'b100;
    localparam logic [2:0] PERM_ALL  = 3'b111;

    // The watchdog allows for the memory clearing pass after reset and for the long output
    // stall, several times over.
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;
    localparam int TAIL        = 40;
    localparam int MAX_REPORTS = 20;

    typedef enum {LAYOUT_PACKED, LAYOUT_EDGES, LAYOUT_RAW} t_layout;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [RANGE_W-1:0]     i_cfg_data  = '0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    t_req                   i_in_req    = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_rsp                   o_out_rsp;

    segmented_protected_memory_access i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the block's registers and of its word memory. The memory starts at
    // zero, as the clearing pass after reset leaves it.
    bit [RANGE_W-1:0] seg_range_model [MAX_SEGMENTS];
    bit [SEGMENTS_DEF*MAP_BITS-1:0] seg_map_model;
    bit prot_model;
    bit [DATA_W-1:0] mem_image [MEMORY_WORDS_DEF];

    // Responses predicted for accepted transactions, oldest first.
    t_rsp expected_rsp [$];

    int mismatches      = 0;
    int results_checked = 0;
    int accesses_seen   = 0;
    int faults_seen     = 0;
    int stores_seen     = 0;
    int settings_seen   = 0;
    int stall_cycles    = 0;

    // Idling control shared by the sender and the receiver.
    bit no_idle   = 1'b0;
    bit hold_req  = 1'b0;
    int hold_left = 0;

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("error: %0s got %h, expected %h (response %0d)",
                     what, got, want, results_checked);
    endtask

    // Works out the response to one access and applies a passing store to the memory image.
    // The first segment whose range holds the address wins; the range end is computed
    // without wrap, so a segment never reaches around to low addresses.
    function automatic t_rsp predict_access(t_req req);
        t_rsp                 rsp;
        logic [1:0]           sz;
        logic [DATA_W-1:0]    lane_mask;
        logic [DATA_W-1:0]    word;
        logic [ADDR_W-1:0]    base;
        logic [ADDR_W-1:0]    paddr;
        logic [MAP_BITS-1:0]  field;
        int                   widx;
        int                   shift;
        bit                   hit;
        bit                   allowed;
        // A fetch is always one byte; the spare size code behaves as a word.
        sz = (req.func == FUNC_FETCH) ? SIZE_BYTE : req.access_size;
        if (sz == SIZE_WIDE)
            sz = SIZE_WORD;
        case (sz)
            SIZE_BYTE: lane_mask = 32'h0000_00FF;
            SIZE_HALF: lane_mask = 32'h0000_FFFF;
            default:   lane_mask = 32'hFFFF_FFFF;
        endcase
        rsp.read_data = lane_mask;
        rsp.fault     = 1'b1;
        hit   = 1'b0;
        base  = '0;
        field = '0;
        accesses_seen++;
        // The spare function code never looks at the segments.
        if (req.func != FUNC_NONE) begin
            for (int i = 0; i < SEGMENTS_DEF; i++) begin
                if (!hit && req.address >= seg_range_model[i][ADDR_W-1:0] &&
                    req.address - seg_range_model[i][ADDR_W-1:0] <
                    seg_range_model[i][RANGE_W-1:ADDR_W]) begin
                    hit   = 1'b1;
                    base  = seg_range_model[i][ADDR_W-1:0];
                    field = seg_map_model[MAP_BITS*i +: MAP_BITS];
                end
            end
        end
        allowed = hit;
        if (hit && prot_model) begin
            case (req.func)
                FUNC_READ:  allowed = field[ATTR_R_BIT];
                FUNC_WRITE: allowed = field[ATTR_W_BIT];
                default:    allowed = field[ATTR_R_BIT] & field[ATTR_X_BIT];
            endcase
        end
        if (allowed) begin
            paddr = {{(ADDR_W-OFFSET_BITS-2){1'b0}}, field[OFFSET_BITS-1:0], 2'b00} +
                    (req.address - base);
            widx  = int'((paddr >> 2) % MEMORY_WORDS_DEF);
            word  = mem_image[widx];
            // Big-endian lanes: byte lane 0 and the lower halfword address sit at the top.
            case (sz)
                SIZE_BYTE: shift = 8 * (3 - int'(paddr[1:0]));
                SIZE_HALF: shift = paddr[1] ? 0 : 16;
                default:   shift = 0;
            endcase
            if (req.func == FUNC_WRITE) begin
                mem_image[widx] = (word & ~(lane_mask << shift)) |
                                  ((req.write_data & lane_mask) << shift);
                rsp.read_data = '0;
                stores_seen++;
            end else begin
                rsp.read_data = (word >> shift) & lane_mask;
            end
            rsp.fault = 1'b0;
        end else begin
            faults_seen++;
        end
        return rsp;
    endfunction

    // Every response is compared with the oldest prediction, then a transaction accepted at
    // the same edge is predicted. Both handshakes are sampled at the rising edge, before the
    // block's registers move.
    always @(posedge i_clk) begin : check_results
        t_rsp want;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_ready) begin
                results_checked++;
                if (expected_rsp.size() == 0) begin
                    report_mismatch("response with no access outstanding",
                                    o_out_rsp.read_data, '0);
                end else begin
                    want = expected_rsp.pop_front();
                    if (o_out_rsp.read_data !== want.read_data)
                        report_mismatch("read_data", o_out_rsp.read_data, want.read_data);
                    if (o_out_rsp.fault !== want.fault)
                        report_mismatch("fault", {31'd0, o_out_rsp.fault}, {31'd0, want.fault});
                end
            end
            if (i_in_valid && o_in_ready === 1'b1)
                expected_rsp.push_back(predict_access(i_in_req));
        end
    end

    // Ends the run when no transaction has moved on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
                     STALL_LIMIT, expected_rsp.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: takes responses with a chance of about three in four, always during a no-idle
    // stretch, and never while a requested long stall is being counted down.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(0, 99) >= 24);
        end
    end

    // Writes one register and keeps the shadow copy in step. Only the low 60 bits of the
    // map and the low bit of the protection switch are kept; spare indexes are dropped.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RANGE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        if (idx < CFG_SEG_MAP)
            seg_range_model[idx] = value;
        else if (idx == CFG_SEG_MAP)
            seg_map_model = value[SEGMENTS_DEF*MAP_BITS-1:0];
        else if (idx == CFG_PROT)
            prot_model = value[0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_segment(int seg, logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] span);
        write_reg(CFG_SEG_RANGE0 + seg[CFG_IDX_W-1:0], {span, base});
    endtask

    // The unused top bits of the map and of the protection switch carry random junk.
    task automatic write_map(logic [MAP_BITS-1:0] f0, logic [MAP_BITS-1:0] f1,
                             logic [MAP_BITS-1:0] f2, logic [MAP_BITS-1:0] f3);
        logic [3:0] junk;
        junk = 4'($urandom);
        write_reg(CFG_SEG_MAP, {junk, f3, f2, f1, f0});
    endtask

    task automatic write_protection(bit enable);
        logic [62:0] junk;
        junk = 63'({$urandom, $urandom});
        write_reg(CFG_PROT, {junk, enable});
        settings_seen++;
    endtask

    function automatic logic [MAP_BITS-1:0] seg_field(logic [OFFSET_BITS-1:0] offset,
                                                       logic [2:0] perms);
        return {perms, offset};
    endfunction

    function automatic t_req build_access(logic [1:0] func, logic [1:0] size,
                                          logic [ADDR_W-1:0] address, logic [DATA_W-1:0] data);
        t_req req;
        req.func        = func;
        req.access_size = size;
        req.address     = address;
        req.write_data  = data;
        return req;
    endfunction

    // Offers one access and returns at the edge where it is accepted. Valid stays high
    // afterwards, so the next call can follow back to back; a random gap drops it first.
    task automatic issue_access(t_req req);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 24)
            gap = $urandom_range(1, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1)
            @(posedge i_clk);
    endtask

    // Drops valid, waits for every outstanding response and lets the block settle.
    // Register writes happen only after this.
    task automatic wait_all_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Mostly addresses inside a segment, some just around its ends, a few anywhere.
    // Large segments are hit near their base half the time so that reads find earlier stores.
    function automatic t_req random_access();
        t_req              req;
        int                seg;
        int                pick;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] span;
        logic [ADDR_W-1:0] window;
        seg  = $urandom_range(0, SEGMENTS_DEF - 1);
        base = seg_range_model[seg][ADDR_W-1:0];
        span = seg_range_model[seg][RANGE_W-1:ADDR_W];
        pick = $urandom_range(0, 99);
        if (pick < 80 && span != 0) begin
            window = (span > 256 && $urandom_range(0, 1)) ? 32'd256 : span;
            req.address = base + ($urandom % window);
        end else if (pick < 92) begin
            case ($urandom_range(0, 2))
                0:       req.address = base - 1;
                1:       req.address = base + span;
                default: req.address = base + span - 1;
            endcase
        end else begin
            req.address = $urandom;
        end
        pick = $urandom_range(0, 99);
        req.func = (pick < 40) ? FUNC_WRITE : (pick < 75) ? FUNC_READ :
                   (pick < 95) ? FUNC_FETCH : FUNC_NONE;
        pick = $urandom_range(0, 99);
        req.access_size = (pick < 30) ? SIZE_BYTE : (pick < 60) ? SIZE_HALF :
                          (pick < 95) ? SIZE_WORD : SIZE_WIDE;
        req.write_data = $urandom;
        return req;
    endfunction

    // Sends random accesses; now and then the sender waits for all responses mid-stream.
    task automatic run_random(int count);
        for (int n = 0; n < count; n++) begin
            issue_access(random_access());
            if ($urandom_range(0, 99) == 0)
                wait_all_results();
        end
    endtask

    // Loads a new segment layout. Packed layouts crowd small, overlapping segments into a
    // few hundred bytes; the edge layout uses the extreme bases, sizes and offsets; the raw
    // layout writes random bits everywhere.
    task automatic apply_layout(t_layout kind, bit enable);
        logic [MAP_BITS-1:0] fields [SEGMENTS_DEF];
        logic [ADDR_W-1:0]   base;
        logic [ADDR_W-1:0]   span;
        for (int i = 0; i < SEGMENTS_DEF; i++) begin
            case (kind)
                LAYOUT_PACKED: begin
                    base = 32'h4000_0000 + $urandom_range(0, 511);
                    span = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 256);
                    fields[i] = seg_field(OFFSET_BITS'($urandom_range(0, 127)),
                                          3'($urandom));
                end
                LAYOUT_EDGES: begin
                    case (i)
                        0:       begin base = 32'h0000_0000; span = $urandom_range(1, 64); end
                        1:       begin base = 32'hFFFF_FFC0; span = 32'hFFFF_FFFF; end
                        2:       begin base = $urandom;      span = 32'h0000_0000; end
                        default: begin base = 32'hFFFF_FFFF; span = 32'hFFFF_FFFF; end
                    endcase
                    fields[i] = seg_field((i == 0) ? 12'h000 : 12'hFFF, PERM_ALL);
                end
                default: begin
                    base = $urandom;
                    span = $urandom;
                    fields[i] = MAP_BITS'($urandom);
                end
            endcase
            write_segment(i, base, span);
        end
        write_map(fields[0], fields[1], fields[2], fields[3]);
        write_protection(enable);
    endtask

    // Straight after reset every segment is empty, so every kind of access misses.
    task automatic test_reset_misses();
        issue_access(build_access(FUNC_READ,  SIZE_WORD, 32'h0000_0000, 32'h0000_0000));
        issue_access(build_access(FUNC_WRITE, SIZE_HALF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        issue_access(build_access(FUNC_FETCH, SIZE_WORD, 32'h0000_1000, 32'h1234_5678));
        wait_all_results();
    endtask

    // Segment 0 is full access and shadows the low quarter of segment 1, which is read only.
    // Segment 2 reaches past the top of the address space with the largest offset and is
    // write and execute only. Segment 3 covers address zero, read and execute.
    task automatic test_protected_segments();
        write_segment(0, 32'h0000_1000, 32'h0000_0100);
        write_segment(1, 32'h0000_1080, 32'h0000_0200);
        write_segment(2, 32'hFFFF_FF00, 32'hFFFF_FFFF);
        write_segment(3, 32'h0000_0000, 32'h0000_0010);
        write_map(seg_field(12'h000, PERM_ALL), seg_field(12'h040, PERM_R),
                  seg_field(12'hFFF, PERM_W | PERM_X), seg_field(12'h080, PERM_R | PERM_X));
        write_protection(1'b1);
        // Word store and load, then a byte store and byte loads on lanes 0, 1 and 3.
        issue_access(build_access(FUNC_WRITE, SIZE_WORD, 32'h0000_1000, 32'hDEAD_BEEF));
        issue_access(build_access(FUNC_READ,  SIZE_WORD, 32'h0000_1000, 32'h0000_0000));
        issue_access(build_access(FUNC_WRITE, SIZE_BYTE, 32'h0000_1001, 32'hFFFF_FFA5));
        issue_access(build_access(FUNC_READ,  SIZE_BYTE, 32'h0000_1000, 32'h0000_0000));
        issue_access(build_access(FUNC_READ,  SIZE_BYTE, 32'h0000_1001, 32'h0000_0000));
        issue_access(build_access(FUNC_READ,  SIZE_BYTE, 32'h0000_1003, 32'h0000_0000));
        // Misaligned halfword and word: the low address bits are dropped.
        issue_access(build_access(FUNC_WRITE, SIZE_HALF, 32'h0000_1003, 32'h0000_C3C3));
        issue_access(build_access(FUNC_READ,  SIZE_HALF, 32'h0000_1001, 32'h0000_0000));
        issue_access(build_access(FUNC_READ,  SIZE_WORD, 32'h0000_1003, 32'h0000_0000));
        // A fetch ignores its size; the spare size code acts as a word.
        issue_access(build_access(FUNC_FETCH, SIZE_WORD, 32'h0000_1002, 32'h0000_0000));
        issue_access(build_access(FUNC_READ,  SIZE_WIDE, 32'h0000_1000, 32'h0000_0000));
        // The spare function code always faults with all ones of the access width.
        issue_access(build_access(FUNC_NONE,  SIZE_HALF, 32'h0000_1000, 32'h0000_0000));
        // Read only segment: a load passes, a store and a fetch are denied.
        issue_access(build_access(FUNC_READ,  SIZE_WORD, 32'h0000_1180, 32'h0000_0000));
        issue_access(build_access(FUNC_WRITE, SIZE_WORD, 32'h0000_1180, 32'h5555_AAAA));
        issue_access(build_access(FUNC_FETCH, SIZE_BYTE, 32'h0000_1180, 32'h0000_0000));
        // Top of the address space: a byte store passes, a load and a fetch are denied.
        issue_access(build_access(FUNC_WRITE, SIZE_BYTE, 32'hFFFF_FFFF, 32'h0000_0000));
        issue_access(build_access(FUNC_READ,  SIZE_BYTE, 32'hFFFF_FFFF, 32'h0000_0000));
        issue_access(build_access(FUNC_FETCH, SIZE_BYTE, 32'hFFFF_FF00, 32'h0000_0000));
        // Read and execute segment at address zero.
        issue_access(build_access(FUNC_FETCH, SIZE_BYTE, 32'h0000_0000, 32'h0000_0000));
        issue_access(build_access(FUNC_WRITE, SIZE_BYTE, 32'h0000_000F, 32'hFFFF_FFFF));
        // An address in no segment faults for a load, a store and a fetch.
        issue_access(build_access(FUNC_READ,  SIZE_HALF, 32'h8000_0000, 32'h0000_0000));
        issue_access(build_access(FUNC_WRITE, SIZE_WORD, 32'h8000_0000, 32'hFFFF_FFFF));
        issue_access(build_access(FUNC_FETCH, SIZE_BYTE, 32'h8000_0000, 32'h0000_0000));
        wait_all_results();
    endtask

    // With protection off any hit passes; an empty segment still never hits.
    task automatic test_unprotected_segments();
        write_segment(3, 32'h0000_0000, 32'h0000_0000);
        write_protection(1'b0);
        issue_access(build_access(FUNC_WRITE, SIZE_WORD, 32'h0000_1180, 32'h0123_4567));
        issue_access(build_access(FUNC_READ,  SIZE_HALF, 32'h0000_1182, 32'h0000_0000));
        issue_access(build_access(FUNC_READ,  SIZE_BYTE, 32'hFFFF_FFFF, 32'h0000_0000));
        issue_access(build_access(FUNC_FETCH, SIZE_BYTE, 32'h0000_1180, 32'h0000_0000));
        issue_access(build_access(FUNC_READ,  SIZE_WORD, 32'h0000_0000, 32'h0000_0000));
        wait_all_results();
    endtask

    // Writes to the two unused indexes must leave the layout as it was.
    task automatic test_spare_registers();
        write_reg(CFG_SPARE_A, {$urandom, $urandom});
        write_reg(CFG_SPARE_B, 64'hFFFF_FFFF_FFFF_FFFF);
        issue_access(build_access(FUNC_READ, SIZE_WORD, 32'h0000_1000, 32'h0000_0000));
        issue_access(build_access(FUNC_READ, SIZE_WORD, 32'h0000_0004, 32'h0000_0000));
        wait_all_results();
    endtask

    task automatic test_random_layouts();
        apply_layout(LAYOUT_PACKED, 1'b1);
        run_random(500);
        wait_all_results();
        apply_layout(LAYOUT_PACKED, 1'b0);
        run_random(400);
        wait_all_results();
        apply_layout(LAYOUT_EDGES, 1'b1);
        run_random(350);
        wait_all_results();
        apply_layout(LAYOUT_RAW, 1'($urandom_range(0, 1)));
        run_random(250);
        wait_all_results();
    endtask

    // Neither side idles, so the block runs at its full rate.
    task automatic test_full_rate_stream();
        apply_layout(LAYOUT_PACKED, 1'b1);
        no_idle = 1'b1;
        run_random(200);
        no_idle = 1'b0;
        wait_all_results();
    endtask

    // The receiver stops for a long stretch while accesses keep coming, so the block
    // fills up and holds its input off until responses drain again.
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        run_random(40);
        wait_all_results();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_misses();
        test_protected_segments();
        test_unprotected_segments();
        test_spare_registers();
        test_random_layouts();
        test_full_rate_stream();
        test_output_backpressure();
        // Anything arriving now has no access behind it and is flagged by the checker.
        repeat (TAIL) @(posedge i_clk);
        $display("Checked %0d responses to %0d accesses over %0d register settings",
                 results_checked, accesses_seen, settings_seen);
        $display("(%0d stores, %0d faults), with full-rate streaming and a long output stall.",
                 stores_seen, faults_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
design/spma_pkg.sv
design/spma_decode.sv
design/spma_word_mod.sv
design/spma_ram.sv
design/segmented_protected_memory_access.sv
tb/sv/segmented_protected_memory_access_tb.sv
